@@ rtl/ubd_pkg.sv @@
// Shared types and constants of the UART baud divisor calculator.
package ubd_pkg;

    // Field and datapath widths
    localparam int BAUD_W    = 24;
    localparam int CLK_W     = 28;
    localparam int NUM_W     = 34;              // 25 * clock, padded to a whole divider pass
    localparam int DEN_W     = 26;              // 4 * baud rate
    localparam int QUO_W     = 32;              // scaled divisor never exceeds 32 bits
    localparam int MANT_W    = 26;              // scaled divisor / 100
    localparam int WORD_W    = 16;
    localparam int STAT_W    = 2;
    localparam int FRAC_W    = 4;
    localparam int REM_W     = 7;               // remainder of / 100
    localparam int FV_W      = 11;              // remainder * 16 + 50
    localparam int FP_W      = 22;              // FV_W * reciprocal product
    localparam int FQ_W      = 5;               // fraction before carry, 0..16
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    // Divider layout: quotient bits retired per stage and stage count
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = NUM_W / DIV_BITS;

    // Reciprocal of 100 for 32-bit operands, and for the fraction numerator
    localparam logic [QUO_W-1:0] RECIP_100   = 32'h51EB_851F;
    localparam int               RECIP_SHIFT = 37;
    localparam logic [FV_W-1:0]  FRAC_RECIP  = 11'd1311;
    localparam int               FRAC_SHIFT  = 17;

    localparam logic [REM_W-1:0] HUNDRED     = 7'd100;
    localparam logic [FV_W-1:0]  ROUND_HALF  = 11'd50;
    localparam logic [FQ_W-1:0]  STEPS_8X    = 5'd8;
    localparam logic [FQ_W-1:0]  STEPS_16X   = 5'd16;
    localparam logic [MANT_W:0]  MANT_MAX    = 27'd4095;
    localparam logic [WORD_W-1:0] WORD_SAT   = 16'hFFFF;

    localparam logic [CLK_W-1:0] CLK_RESET   = 28'd16000000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_CLK = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_CLK = 8'd1;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAUD_ZERO = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    // One beat in flight through the divider
    typedef struct packed {
        logic [NUM_W-1:0] num;      // numerator bits left, quotient bits shifted in
        logic [DEN_W-1:0] rem;      // partial remainder
        logic [DEN_W-1:0] den;      // divisor
        logic             by8;      // 8x oversampling
        logic             zero;     // baud rate was zero
    } div_beat_t;

endpackage

@@ rtl/ubd_front.sv @@
// Input stage: bus clock select, numerator and denominator setup.
module ubd_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [ubd_pkg::BAUD_W-1:0]   baud_rate,
    input  logic                         oversample_by_8,
    input  logic                         use_fast_bus,
    input  logic [ubd_pkg::CLK_W-1:0]    slow_clk,
    input  logic [ubd_pkg::CLK_W-1:0]    fast_clk,
    output logic                         valid_reg,
    output ubd_pkg::div_beat_t           beat_reg
);
    import ubd_pkg::*;

    logic [CLK_W-1:0]   clk_sel;
    logic [NUM_W-2:0]   clk_ext;
    logic [NUM_W-2:0]   clk25;
    div_beat_t          beat_next;

    // Pick the bus clock and scale it by 25 with shifts and adds
    always_comb begin
        clk_sel = use_fast_bus ? fast_clk : slow_clk;
        clk_ext = {{(NUM_W-1-CLK_W){1'b0}}, clk_sel};
        clk25   = (clk_ext << 4) + (clk_ext << 3) + clk_ext;

        beat_next.num  = {1'b0, clk25};
        beat_next.rem  = '0;
        beat_next.den  = oversample_by_8 ? {1'b0, baud_rate, 1'b0} : {baud_rate, 2'b00};
        beat_next.by8  = oversample_by_8;
        beat_next.zero = (baud_rate == '0);
    end

    // Hold valid under reset, advance with the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            beat_reg <= beat_next;
        end
    end

endmodule

@@ rtl/ubd_div_stage.sv @@
// One stage of the pipelined restoring divider.
module ubd_div_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 valid_in,
    input  ubd_pkg::div_beat_t   beat_in,
    output logic                 valid_reg,
    output ubd_pkg::div_beat_t   beat_reg
);
    import ubd_pkg::*;

    logic [DEN_W:0]   shifted;
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] num;
    div_beat_t        beat_next;

    // Retire DIV_BITS quotient bits: shift, compare, subtract
    always_comb begin
        rem     = beat_in.rem;
        num     = beat_in.num;
        shifted = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            shifted = {rem, num[NUM_W-1]};
            num     = {num[NUM_W-2:0], 1'b0};
            if (shifted >= {1'b0, beat_in.den}) begin
                shifted = shifted - {1'b0, beat_in.den};
                num[0]  = 1'b1;
            end
            rem = shifted[DEN_W-1:0];
        end
        beat_next     = beat_in;
        beat_next.rem = rem;
        beat_next.num = num;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            beat_reg <= beat_next;
        end
    end

    // Partial remainder stays below the divisor
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !beat_reg.zero |-> beat_reg.rem < beat_reg.den)
        else $error("divider remainder not below divisor");

endmodule

@@ rtl/ubd_post.sv @@
// Back end: mantissa and fraction by reciprocal, rounding carry, packing.
module ubd_post (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          valid_in,
    input  ubd_pkg::div_beat_t            beat_in,
    output logic                          valid_reg,
    output logic [ubd_pkg::WORD_W-1:0]    word_reg,
    output logic [ubd_pkg::STAT_W-1:0]    status_reg
);
    import ubd_pkg::*;

    // Stage 1: mantissa = quotient / 100
    logic                s1_valid_reg;
    logic [MANT_W-1:0]   s1_mant_reg;
    logic [REM_W-1:0]    s1_qlo_reg;
    logic                s1_by8_reg;
    logic                s1_zero_reg;
    logic [QUO_W-1:0]    quo;
    logic [2*QUO_W-1:0]  prod;

    // Stage 2: remainder and fraction numerator
    logic                s2_valid_reg;
    logic [MANT_W-1:0]   s2_mant_reg;
    logic [FV_W-1:0]     s2_fv_reg;
    logic                s2_by8_reg;
    logic                s2_zero_reg;
    logic [2*REM_W-1:0]  m100;
    logic [REM_W-1:0]    rem7;
    logic [FV_W-1:0]     fv_next;

    // Stage 3: fraction = numerator / 100
    logic                s3_valid_reg;
    logic [MANT_W-1:0]   s3_mant_reg;
    logic [FQ_W-1:0]     s3_frac_reg;
    logic                s3_by8_reg;
    logic                s3_zero_reg;
    logic [FP_W-1:0]     fp;

    // Stage 4: carry, saturation, packing
    logic [FQ_W-1:0]     steps;
    logic                carry;
    logic [MANT_W:0]     mant_c;
    logic [FRAC_W-1:0]   frac4;
    logic [WORD_W-1:0]   word_next;
    status_t             status_next;

    assign quo  = beat_in.num[QUO_W-1:0];
    assign prod = {{QUO_W{1'b0}}, quo} * {{QUO_W{1'b0}}, RECIP_100};

    assign m100    = {{REM_W{1'b0}}, s1_mant_reg[REM_W-1:0]} * {{REM_W{1'b0}}, HUNDRED};
    assign rem7    = s1_qlo_reg - m100[REM_W-1:0];
    assign fv_next = (s1_by8_reg ? {1'b0, rem7, 3'b000} : {rem7, 4'b0000}) + ROUND_HALF;

    assign fp = {{(FP_W-FV_W){1'b0}}, s2_fv_reg} * {{(FP_W-FV_W){1'b0}}, FRAC_RECIP};

    // Carry a full fraction step into the mantissa, then saturate
    always_comb begin
        steps  = s3_by8_reg ? STEPS_8X : STEPS_16X;
        carry  = (s3_frac_reg >= steps);
        mant_c = {1'b0, s3_mant_reg} + {{MANT_W{1'b0}}, carry};
        frac4  = carry ? '0
               : (s3_by8_reg ? {1'b0, s3_frac_reg[2:0]} : s3_frac_reg[FRAC_W-1:0]);
        if (s3_zero_reg) begin
            word_next   = '0;
            status_next = ST_BAUD_ZERO;
        end else if (mant_c > MANT_MAX) begin
            word_next   = WORD_SAT;
            status_next = ST_OVERFLOW;
        end else begin
            word_next   = {mant_c[WORD_W-FRAC_W-1:0], frac4};
            status_next = ST_OK;
        end
    end

    // Valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= valid_in;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            valid_reg    <= s3_valid_reg;
        end
    end

    // Payload chain
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_mant_reg <= prod[RECIP_SHIFT+MANT_W-1:RECIP_SHIFT];
            s1_qlo_reg  <= quo[REM_W-1:0];
            s1_by8_reg  <= beat_in.by8;
            s1_zero_reg <= beat_in.zero;

            s2_mant_reg <= s1_mant_reg;
            s2_fv_reg   <= fv_next;
            s2_by8_reg  <= s1_by8_reg;
            s2_zero_reg <= s1_zero_reg;

            s3_mant_reg <= s2_mant_reg;
            s3_frac_reg <= fp[FRAC_SHIFT+FQ_W-1:FRAC_SHIFT];
            s3_by8_reg  <= s2_by8_reg;
            s3_zero_reg <= s2_zero_reg;

            word_reg    <= word_next;
            status_reg  <= status_next;
        end
    end

    // Remainder of / 100 is below 100, so the numerator stays below 1650
    a_fv_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg && !s2_zero_reg |-> s2_fv_reg < 11'd1650)
        else $error("fraction numerator out of range");

    // Rounded fraction never exceeds one full step
    a_frac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg && !s3_zero_reg |-> s3_frac_reg <= (s3_by8_reg ? STEPS_8X : STEPS_16X))
        else $error("rounded fraction above one step");

endmodule

@@ rtl/uart_baud_divisor_calc.sv @@
// UART baud divisor calculator top level: config registers, pipeline, stream ports.
//
// Takes one request beat per cycle and returns one result beat per request, in order,
// after the request has passed one input stage, a 17-stage restoring divider
// that retires two quotient bits per stage on the 34-bit numerator 25*clock, and four
// stages that split off the mantissa and rounded fraction by multiplying with
// reciprocals of 100, carry a full fraction step, saturate and pack. The whole pipeline
// freezes while a result beat waits on m_tready, so s_tready follows m_tready whenever
// the output register is full. Status 1 marks a zero baud rate (word 0), status 2 a
// mantissa above 4095 (word 0xFFFF). Write the bus clock registers only while no
// request is in flight.
module uart_baud_divisor_calc (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,    // [23:0] baud_rate
    input  logic [1:0]                      s_tuser,    // [0] oversample_by_8, [1] use_fast_bus
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,    // [15:0] divisor_word
    output logic [1:0]                      m_tuser,    // [1:0] status
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ubd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ubd_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import ubd_pkg::*;

    logic              adv;
    logic [CLK_W-1:0]  slow_clk_reg;
    logic [CLK_W-1:0]  fast_clk_reg;
    logic              div_valid [0:DIV_STAGES];
    div_beat_t         div_beat  [0:DIV_STAGES];

    // Advance the pipeline whenever the output register is free or being drained
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    // Bus clock registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slow_clk_reg <= CLK_RESET;
            fast_clk_reg <= CLK_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SLOW_CLK: slow_clk_reg <= cfg_data[CLK_W-1:0];
                CFG_FAST_CLK: fast_clk_reg <= cfg_data[CLK_W-1:0];
                default: ;
            endcase
        end
    end

    ubd_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .adv             (adv),
        .in_valid        (s_tvalid),
        .baud_rate       (s_tdata),
        .oversample_by_8 (s_tuser[0]),
        .use_fast_bus    (s_tuser[1]),
        .slow_clk        (slow_clk_reg),
        .fast_clk        (fast_clk_reg),
        .valid_reg       (div_valid[0]),
        .beat_reg        (div_beat[0])
    );

    // Divider stages
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        ubd_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .valid_in  (div_valid[g]),
            .beat_in   (div_beat[g]),
            .valid_reg (div_valid[g+1]),
            .beat_reg  (div_beat[g+1])
        );
    end

    ubd_post u_post (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .valid_in   (div_valid[DIV_STAGES]),
        .beat_in    (div_beat[DIV_STAGES]),
        .valid_reg  (m_tvalid),
        .word_reg   (m_tdata),
        .status_reg (m_tuser)
    );

    // Only the three defined status codes leave the block
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("undefined status code");

    // Zero baud rate always reports an empty word
    a_zero_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_BAUD_ZERO |-> m_tdata == '0)
        else $error("zero baud rate with nonzero word");

    // Overflow always reports the saturated word
    a_sat_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_OVERFLOW |-> m_tdata == WORD_SAT)
        else $error("overflow without saturated word");

endmodule

@@ bench/tb_uart_baud_divisor_calc.sv @@
// Testbench for the UART baud divisor calculator: streamed requests checked against a predictor.
`timescale 1ns / 1ps

module tb_uart_baud_divisor_calc;
    import ubd_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned SEGMENTS      = 6;
    localparam int unsigned SEGMENT_ITEMS = 290;
    localparam int unsigned REPORT_MAX    = 10;
    localparam int unsigned DRAIN_AT      = 100;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hFF;
    localparam int unsigned LINE_RATES [0:17] = '{300, 1200, 2400, 4800, 9600, 19200,
        38400, 57600, 115200, 230400, 460800, 921600, 1000000, 2000000, 3000000,
        4000000, 6000000, 12000000};

    typedef struct {
        logic [BAUD_W-1:0] baud;
        logic              by8;
        logic              fast;
        logic              drain_first;   // hold this beat until every result is back
    } baud_request_t;

    typedef struct {
        logic [WORD_W-1:0] word;
        status_t           status;
    } divisor_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata   = '0;   // [23:0] baud_rate
    logic [1:0]           s_tuser   = '0;   // [0] oversample_by_8, [1] use_fast_bus
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [15:0]          m_tdata;          // [15:0] divisor_word
    logic [1:0]           m_tuser;          // [1:0] status
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    // predictor copy of the bus clock registers
    logic [CLK_W-1:0]     slow_hz = CLK_RESET;
    logic [CLK_W-1:0]     fast_hz = CLK_RESET;

    baud_request_t        pending_requests[$];
    divisor_result_t      expected_divisors[$];
    int unsigned          req_beats      = 0;
    int unsigned          req_presented  = 0;
    int unsigned          cfg_beats      = 0;
    int unsigned          mismatch_count = 0;
    int unsigned          cycle_count    = 0;
    int unsigned          send_idle_pct  = 32;
    int unsigned          recv_idle_pct  = 83;

    uart_baud_divisor_calc u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Compute the packed divisor word and status for one request
    function automatic divisor_result_t divisor_of(logic [BAUD_W-1:0] baud, logic by8,
                                                   logic fast);
        divisor_result_t r;
        logic [63:0]     bus_hz;
        logic [63:0]     scaled;
        logic [63:0]     mant;
        logic [63:0]     rem;
        logic [63:0]     steps;
        logic [63:0]     frac;
        bus_hz = fast ? 64'(fast_hz) : 64'(slow_hz);
        if (baud == '0) begin
            r.word   = '0;
            r.status = ST_BAUD_ZERO;
        end else begin
            // divisor scaled by 100, then split into mantissa and rounded fraction
            scaled = (64'd25 * bus_hz) / ((by8 ? 64'd2 : 64'd4) * 64'(baud));
            mant   = scaled / 64'd100;
            rem    = scaled - mant * 64'd100;
            steps  = by8 ? 64'd8 : 64'd16;
            frac   = (rem * steps + 64'd50) / 64'd100;
            // carry a full fraction step into the mantissa
            if (frac >= steps) begin
                mant = mant + 64'd1;
                frac = '0;
            end
            if (mant > 64'(MANT_MAX)) begin
                r.word   = WORD_SAT;
                r.status = ST_OVERFLOW;
            end else begin
                r.word   = {mant[11:0], by8 ? {1'b0, frac[2:0]} : frac[3:0]};
                r.status = ST_OK;
            end
        end
        return r;
    endfunction

    // Draw a baud rate: mostly common line rates and in-range values, some edge values
    function automatic logic [BAUD_W-1:0] pick_baud();
        logic [BAUD_W-1:0] b;
        case ($urandom_range(19))
            0:       b = '0;
            1, 2, 3: b = BAUD_W'(LINE_RATES[$urandom_range(17)]);
            4, 5:    b = BAUD_W'($urandom_range(5000, 1));
            6, 7:    b = BAUD_W'($urandom);
            default: b = BAUD_W'($urandom_range(12000000, 1000));
        endcase
        return b;
    endfunction

    task automatic queue_request(input logic [BAUD_W-1:0] baud, input logic by8,
                                 input logic fast, input logic drain_first);
        baud_request_t req;
        req.baud        = baud;
        req.by8         = by8;
        req.fast        = fast;
        req.drain_first = drain_first;
        pending_requests.push_back(req);
    endtask

    // Write one register and hold until the beat is taken
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        int unsigned taken_before;
        taken_before = cfg_beats;
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(negedge aclk); while (cfg_beats == taken_before);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every request is taken and every result has come back
    task automatic wait_until_idle();
        do @(negedge aclk);
        while (pending_requests.size() != 0 || expected_divisors.size() != 0
               || req_beats != req_presented);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("mismatch at cycle %0d: %s expected 0x%0h got 0x%0h",
                     cycle_count, what, want, got);
    endtask

    // Request driver: present the next pending beat, hold it until taken
    always @(negedge aclk) begin : drive_requests
        baud_request_t next_req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (req_beats == req_presented) begin
            if (pending_requests.size() != 0
                && !(pending_requests[0].drain_first && expected_divisors.size() != 0)
                && $urandom_range(99) >= send_idle_pct) begin
                next_req = pending_requests.pop_front();
                req_presented++;
                s_tvalid <= 1'b1;
                s_tdata  <= next_req.baud;
                s_tuser  <= {next_req.fast, next_req.by8};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result backpressure
    always @(negedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: track config and request beats, check result beats in order
    always @(posedge aclk) begin : track_beats
        divisor_result_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                cfg_beats++;
                case (cfg_index)
                    CFG_SLOW_CLK: slow_hz = cfg_data[CLK_W-1:0];
                    CFG_FAST_CLK: fast_hz = cfg_data[CLK_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                req_beats++;
                expected_divisors.push_back(divisor_of(s_tdata, s_tuser[0], s_tuser[1]));
            end
            if (m_tvalid && m_tready) begin
                if (expected_divisors.size() == 0) begin
                    flag_mismatch("unexpected result beat, word", '0, 32'(m_tdata));
                end else begin
                    want = expected_divisors.pop_front();
                    if (m_tdata !== want.word)
                        flag_mismatch("divisor_word", 32'(want.word), 32'(m_tdata));
                    if (m_tuser !== want.status)
                        flag_mismatch("status", 32'(want.status), 32'(m_tuser));
                end
            end
        end
    end

    // Give up on a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[uart_baud_divisor_calc] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset clocks, zero baud, carries, overflow edge, tiny divisor
        queue_request(24'd0, 1'b0, 1'b0, 1'b0);
        queue_request(24'd0, 1'b1, 1'b1, 1'b0);
        queue_request(24'd115200, 1'b0, 1'b0, 1'b0);
        queue_request(24'd115200, 1'b1, 1'b1, 1'b0);
        queue_request(24'd9600, 1'b0, 1'b1, 1'b0);
        queue_request(24'd100300, 1'b0, 1'b0, 1'b0);   // 16x fraction rounds to 16
        queue_request(24'd201005, 1'b1, 1'b0, 1'b0);   // 8x fraction rounds to 8
        queue_request(24'd244, 1'b0, 1'b0, 1'b0);      // just over the mantissa limit
        queue_request(24'd245, 1'b0, 1'b1, 1'b0);      // just under it
        queue_request(24'd1, 1'b1, 1'b0, 1'b0);
        queue_request(24'hFFFFFF, 1'b1, 1'b1, 1'b0);   // mantissa zero
        queue_request(24'd12000000, 1'b0, 1'b1, 1'b0);

        // Directed: full-scale slow clock, zero fast clock, unmapped writes
        wait_until_idle();
        write_reg(CFG_SLOW_CLK, 32'hFFFF_FFFF);
        write_reg(CFG_FAST_CLK, 32'h0000_0000);
        write_reg(CFG_FAST_CLK + 8'd1, 32'h0000_007B);
        write_reg(CFG_UNMAPPED, 32'hFFFF_FFFF);
        @(posedge aclk);
        queue_request(24'd1, 1'b1, 1'b0, 1'b0);
        queue_request(24'd1, 1'b0, 1'b0, 1'b0);
        queue_request(24'hFFFFFF, 1'b0, 1'b0, 1'b0);
        queue_request(24'd12000000, 1'b1, 1'b0, 1'b0);
        queue_request(24'd9600, 1'b0, 1'b1, 1'b0);
        queue_request(24'hFFFFFF, 1'b1, 1'b1, 1'b0);
        queue_request(24'd0, 1'b0, 1'b1, 1'b0);
        queue_request(24'd115200, 1'b1, 1'b0, 1'b1);

        // Random segments, each with its own clock setting; the idle pattern changes every two segments
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            wait_until_idle();
            case (seg)
                0: begin
                    write_reg(CFG_SLOW_CLK, 32'd200000000);
                    write_reg(CFG_FAST_CLK, 32'd16000000);
                end
                1: begin
                    write_reg(CFG_SLOW_CLK, 32'd14745600);
                    write_reg(CFG_FAST_CLK, 32'd84000000);
                end
                2: begin
                    write_reg(CFG_SLOW_CLK, $urandom);
                    write_reg(CFG_FAST_CLK, 32'd42000000);
                end
                3: begin
                    write_reg(CFG_SLOW_CLK, 32'd1843200);
                    write_reg(CFG_FAST_CLK, 32'd200000000);
                end
                4: begin
                    write_reg(CFG_SLOW_CLK, $urandom_range(200000000, 1));
                    write_reg(CFG_FAST_CLK, $urandom);
                end
                default: begin
                    write_reg(CFG_SLOW_CLK, 32'h0FFF_FFFF);
                    write_reg(CFG_FAST_CLK, 32'd1);
                end
            endcase
            write_reg(CFG_IDX_W'($urandom_range(255, 2)), $urandom);
            @(posedge aclk);
            send_idle_pct = (seg < 2) ? 32 : (seg < 4) ? 83 : 0;
            recv_idle_pct = (seg < 2) ? 83 : (seg < 4) ? 32 : 0;
            for (int n = 0; n < SEGMENT_ITEMS; n++)
                queue_request(pick_baud(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                              n == DRAIN_AT || $urandom_range(63) == 0);
        end

        // Drain, then allow for stray beats over the pipeline depth
        wait_until_idle();
        repeat (40) @(negedge aclk);
        if (mismatch_count == 0 && expected_divisors.size() == 0)
            $display("[uart_baud_divisor_calc] OK");
        else
            $display("[uart_baud_divisor_calc] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ubd_pkg.sv
rtl/ubd_front.sv
rtl/ubd_div_stage.sv
rtl/ubd_post.sv
rtl/uart_baud_divisor_calc.sv
bench/tb_uart_baud_divisor_calc.sv
